// File: src/dti_pkg.sv
`timescale 1ns / 1ps

package dti_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRY_W     = 63;

    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_STATION_X    = 3'd0;
    localparam logic [2:0] REG_STATION_Y    = 3'd1;
    localparam logic [2:0] REG_STATION_Z    = 3'd2;
    localparam logic [2:0] REG_THREE_D_MODE = 3'd3;
    localparam logic [2:0] REG_TABLE_COUNT  = 3'd4;

    localparam logic [1:0] ST_INTERP   = 2'd0;
    localparam logic [1:0] ST_BEYOND   = 2'd1;
    localparam logic [1:0] ST_ZERO_SEG = 2'd2;
    localparam logic [1:0] ST_THREE_D  = 2'd3;

endpackage

// File: src/dti_ram.sv
`timescale 1ns / 1ps

module dti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/distance_table_interpolator.sv
`timescale 1ns / 1ps
// write transfer: the table entry is stored at the edge on which the transfer is accepted
// query: from transfer to result valid the block runs 3 multiply steps, 30 arccos rounds
// on one squarer, a binary search of up to 6 steps, and 34 divider steps
// three-d mode skips to the done state; one query at a time, s_ready low until the result loads
// reset (aresetn low, synchronous) clears control state and loads register defaults;
// the table ram is not cleared

module distance_table_interpolator
    import dti_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [5:0]         s_entry_index,
    input  logic [30:0]        s_entry_distance,
    input  logic signed [31:0] s_entry_value,
    input  logic signed [31:0] s_query_x,
    input  logic signed [31:0] s_query_y,
    input  logic signed [31:0] s_query_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_uncertainty,
    output logic [1:0]         m_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_DOT, S_CLAMP, S_ACOS, S_ANGLE, S_RD_LAST, S_CHK_LAST, S_SRCH,
        S_SRCH_CMP, S_RD_LO, S_RD_HI, S_SEG, S_MULT, S_DIVCHK, S_DIV, S_FINAL, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [31:0] station_x_reg, station_y_reg, station_z_reg;
    logic               three_d_mode_reg;
    logic [6:0]         table_count_reg;

    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] acc_reg;
    logic signed [32:0] c_reg;
    logic               b_reg;
    logic [29:0]        t_reg;
    logic [5:0]         cnt_reg;
    logic [30:0]        angle_reg;
    logic [IDX_W-1:0]   lo_reg, hi_reg, mid_reg;
    logic [30:0]        d0_reg;
    logic signed [31:0] v0_reg;
    logic [30:0]        num_mag_reg;
    logic [31:0]        dv_mag_reg;
    logic [30:0]        aden_reg;
    logic               neg_reg;
    logic [63:0]        rem_reg, dsr_reg;
    logic [33:0]        q_reg;
    logic signed [31:0] res_val_reg;
    logic [1:0]         res_stat_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_uncertainty_reg;
    logic [1:0]         m_status_reg;

    // config port
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_STATION_X:    prdata = station_x_reg;
            REG_STATION_Y:    prdata = station_y_reg;
            REG_STATION_Z:    prdata = station_z_reg;
            REG_THREE_D_MODE: prdata = {31'b0, three_d_mode_reg};
            REG_TABLE_COUNT:  prdata = {25'b0, table_count_reg};
            default:          prdata = 32'b0;
        endcase
    end

    // table ram
    logic               s_xfer;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [30:0]        rd_dist;
    logic signed [31:0] rd_val;

    assign s_ready = (state_reg == S_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign wr_en   = s_xfer && (s_operation == OP_WRITE) && (32'(s_entry_index) < TABLE_DEPTH);
    assign rd_dist = rd_data[62:32];
    assign rd_val  = rd_data[31:0];

    dti_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(s_entry_index)),
        .wr_data ({s_entry_distance, s_entry_value}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // table size
    logic [CNT_W-1:0] n_sat;
    logic [IDX_W-1:0] n_last;

    always_comb begin
        if (table_count_reg < 7'd2) begin
            n_sat = CNT_W'(2);
        end else if (32'(table_count_reg) > TABLE_DEPTH) begin
            n_sat = CNT_W'(TABLE_DEPTH);
        end else begin
            n_sat = CNT_W'(table_count_reg);
        end
        n_last = IDX_W'(n_sat - CNT_W'(1));
    end

    // search
    logic [CNT_W-1:0] span;
    logic [IDX_W-1:0] mid;

    assign span = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign mid  = IDX_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    always_comb begin
        case (state_reg)
            S_RD_LAST: rd_addr = n_last;
            S_SRCH:    rd_addr = mid;
            S_RD_LO:   rd_addr = lo_reg;
            S_RD_HI:   rd_addr = IDX_W'(lo_reg + IDX_W'(1));
            default:   rd_addr = '0;
        endcase
    end

    // dot product
    logic signed [31:0] sa, qa;
    logic signed [63:0] dprod;
    logic signed [63:0] dot_cl;

    always_comb begin
        case (k_reg)
            2'd0:    begin sa = station_x_reg; qa = qx_reg; end
            2'd1:    begin sa = station_y_reg; qa = qy_reg; end
            default: begin sa = station_z_reg; qa = qz_reg; end
        endcase
        dprod = sa * qa;
        if (acc_reg > 64'sh0400_0000_0000_0000) begin
            dot_cl = 64'sh0400_0000_0000_0000;
        end else if (acc_reg < -64'sh0400_0000_0000_0000) begin
            dot_cl = -64'sh0400_0000_0000_0000;
        end else begin
            dot_cl = acc_reg;
        end
    end

    // arccos round
    logic [31:0]        c_mag;
    logic [63:0]        sq;
    logic [32:0]        sq_sh;
    logic signed [34:0] c_new;
    logic               b_new;
    logic [61:0]        ang_full;

    assign c_mag    = c_reg[32] ? 32'(-c_reg) : 32'(c_reg);
    assign sq       = c_mag * c_mag;
    assign sq_sh    = 33'((sq + 64'h2000_0000) >> 30);
    assign c_new    = $signed({2'b0, sq_sh}) - 35'sh0_8000_0000;
    assign b_new    = b_reg ^ c_reg[32];
    assign ang_full = 62'(t_reg * PI_Q29) + 62'h2000_0000;

    // segment
    logic signed [31:0] den, num;
    logic signed [32:0] dv;
    logic [62:0]        aprod;

    assign den   = $signed({1'b0, rd_dist}) - $signed({1'b0, d0_reg});
    assign num   = $signed({1'b0, angle_reg}) - $signed({1'b0, d0_reg});
    assign dv    = $signed({rd_val[31], rd_val}) - $signed({v0_reg[31], v0_reg});
    assign aprod = num_mag_reg * dv_mag_reg;

    // final sum
    logic [33:0]        q_cap;
    logic signed [34:0] q_sg;
    logic signed [35:0] sum;

    assign q_cap = (q_reg > 34'h2_0000_0000) ? 34'h2_0000_0000 : q_reg;
    assign q_sg  = neg_reg ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
    assign sum   = $signed({{4{v0_reg[31]}}, v0_reg}) + $signed({q_sg[34], q_sg});

    // result register load
    logic out_load;

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            station_x_reg    <= 32'sh4000_0000;
            station_y_reg    <= '0;
            station_z_reg    <= '0;
            three_d_mode_reg <= 1'b0;
            table_count_reg  <= 7'd2;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_STATION_X:    station_x_reg    <= pwdata;
                    REG_STATION_Y:    station_y_reg    <= pwdata;
                    REG_STATION_Z:    station_z_reg    <= pwdata;
                    REG_THREE_D_MODE: three_d_mode_reg <= pwdata[0];
                    REG_TABLE_COUNT:  table_count_reg  <= pwdata[6:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer && s_operation == OP_QUERY) begin
                        qx_reg  <= s_query_x;
                        qy_reg  <= s_query_y;
                        qz_reg  <= s_query_z;
                        k_reg   <= 2'd0;
                        acc_reg <= '0;
                        if (three_d_mode_reg) begin
                            res_val_reg  <= '0;
                            res_stat_reg <= ST_THREE_D;
                            state_reg    <= S_DONE;
                        end else begin
                            state_reg <= S_DOT;
                        end
                    end
                end
                S_DOT: begin
                    acc_reg <= acc_reg + (dprod >>> 2);
                    k_reg   <= k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    c_reg     <= 33'(dot_cl >>> 27);
                    b_reg     <= 1'b0;
                    t_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ACOS;
                end
                S_ACOS: begin
                    b_reg   <= b_new;
                    t_reg   <= {t_reg[28:0], b_new};
                    c_reg   <= 33'(c_new);
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd29) begin
                        state_reg <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    angle_reg <= 31'(ang_full >> 30);
                    state_reg <= S_RD_LAST;
                end
                S_RD_LAST: begin
                    state_reg <= S_CHK_LAST;
                end
                S_CHK_LAST: begin
                    if (angle_reg > rd_dist) begin
                        res_val_reg  <= rd_val;
                        res_stat_reg <= ST_BEYOND;
                        state_reg    <= S_DONE;
                    end else begin
                        lo_reg    <= '0;
                        hi_reg    <= n_last;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (span > CNT_W'(1)) begin
                        mid_reg   <= mid;
                        state_reg <= S_SRCH_CMP;
                    end else begin
                        state_reg <= S_RD_LO;
                    end
                end
                S_SRCH_CMP: begin
                    if (rd_dist <= angle_reg) begin
                        lo_reg <= mid_reg;
                    end else begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_SRCH;
                end
                S_RD_LO: begin
                    state_reg <= S_RD_HI;
                end
                S_RD_HI: begin
                    d0_reg    <= rd_dist;
                    v0_reg    <= rd_val;
                    state_reg <= S_SEG;
                end
                S_SEG: begin
                    if (den == 32'sd0) begin
                        res_val_reg  <= '0;
                        res_stat_reg <= ST_ZERO_SEG;
                        state_reg    <= S_DONE;
                    end else begin
                        num_mag_reg <= num[31] ? 31'(-num) : 31'(num);
                        dv_mag_reg  <= dv[32] ? 32'(-dv) : 32'(dv);
                        aden_reg    <= den[31] ? 31'(-den) : 31'(den);
                        neg_reg     <= num[31] ^ dv[32] ^ den[31];
                        state_reg   <= S_MULT;
                    end
                end
                S_MULT: begin
                    rem_reg   <= {1'b0, aprod} + {33'b0, aden_reg[30:1]};
                    state_reg <= S_DIVCHK;
                end
                S_DIVCHK: begin
                    if ({1'b0, rem_reg} >= {aden_reg, 34'b0}) begin
                        q_reg     <= 34'h2_0000_0000;
                        state_reg <= S_FINAL;
                    end else begin
                        q_reg     <= '0;
                        dsr_reg   <= {aden_reg, 33'b0};
                        cnt_reg   <= 6'd33;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_reg >= dsr_reg) begin
                        rem_reg <= rem_reg - dsr_reg;
                        q_reg   <= {q_reg[32:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[32:0], 1'b0};
                    end
                    dsr_reg <= dsr_reg >> 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    if (sum > 36'sd2147483647) begin
                        res_val_reg <= 32'sh7fff_ffff;
                    end else if (sum < -36'sd2147483648) begin
                        res_val_reg <= 32'sh8000_0000;
                    end else begin
                        res_val_reg <= 32'(sum);
                    end
                    res_stat_reg <= ST_INTERP;
                    state_reg    <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        m_uncertainty_reg <= res_val_reg;
                        m_status_reg      <= res_stat_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_uncertainty = m_uncertainty_reg;
    assign m_status      = m_status_reg;

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result transfer raised outside done state");

    a_query_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_operation == OP_QUERY |=> state_reg != S_IDLE)
        else $error("query transfer did not start work");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_operation == OP_WRITE |=> state_reg == S_IDLE)
        else $error("write transfer started a query");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> cnt_reg <= 6'd33)
        else $error("divider step count out of range");

    a_zero_seg_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_ZERO_SEG || m_status_reg == ST_THREE_D)
        |-> m_uncertainty_reg == 32'sd0)
        else $error("flagged result carries a nonzero value");

endmodule
